// ----- rtl/bfg_pkg.sv -----
`timescale 1ns / 1ps
package bfg_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_RADIUS = 3;
	localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
	localparam int LINES      = WIN_SIDE - 1;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int WIN_IDX_W  = $clog2(WIN_SIDE);

	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int RAD_W    = 2;
	localparam int FACTOR_W = 16;
	localparam int ROW_W    = 12;
	localparam int COL_W    = 10;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR = CFG_IDX_W'(3);

	// Q0.16 luma weights; they sum to exactly 65536.
	localparam logic [15:0] W_GREY_A = 16'd19595;
	localparam logic [15:0] W_GREY_B = 16'd38470;
	localparam logic [15:0] W_GREY_C = 16'd7471;

	typedef logic [7:0] byte_t;
	typedef byte_t [2:0] rgb_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] frow;
		logic [COL_W-1:0] fcol;
		logic             emit_f;
		logic             emit_g;
	} pos_t;
endpackage

// ----- rtl/bfg_if.sv -----
`timescale 1ns / 1ps
interface pix_if;
	logic                 valid;
	logic                 ready;
	logic [7:0]           chan_a;
	logic [7:0]           chan_b;
	logic [7:0]           chan_c;
	modport source(output valid, chan_a, chan_b, chan_c, input ready);
	modport sink(input valid, chan_a, chan_b, chan_c, output ready);
endinterface

interface res_if;
	logic                      valid;
	logic                      ready;
	logic [bfg_pkg::ROW_W-1:0] out_row;
	logic [bfg_pkg::COL_W-1:0] out_col;
	logic [7:0]                res_a;
	logic [7:0]                res_b;
	logic [7:0]                res_c;
	logic                      is_filtered;
	logic                      last_of_run;
	modport source(output valid, out_row, out_col, res_a, res_b, res_c, is_filtered,
		last_of_run, input ready);
	modport sink(input valid, out_row, out_col, res_a, res_b, res_c, is_filtered,
		last_of_run, output ready);
endinterface

interface cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bfg_pkg::CFG_IDX_W-1:0]  index;
	logic [bfg_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/bfg_ctrl.sv -----
`timescale 1ns / 1ps
module bfg_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  bfg_pkg::rgb_t                  in_pix,
	input  logic [bfg_pkg::WIDTH_W-1:0]    width,
	input  logic [bfg_pkg::HEIGHT_W-1:0]   height,
	input  logic [bfg_pkg::RAD_W-1:0]      radius,
	output logic                           v_s1,
	output bfg_pkg::pos_t                  pos_s1,
	output bfg_pkg::rgb_t                  pix_s1
);
	logic [bfg_pkg::ROW_W-1:0]    row_q;
	logic [bfg_pkg::COL_W-1:0]    col_q;
	logic [bfg_pkg::WIDTH_W-1:0]  w_eff;
	logic [bfg_pkg::HEIGHT_W-1:0] h_eff;
	logic [bfg_pkg::HEIGHT_W-1:0] row_x, row_nx;
	logic [bfg_pkg::WIDTH_W-1:0]  col_x, col_nx;
	logic [bfg_pkg::HEIGHT_W-1:0] r_x, r2_x;
	logic [bfg_pkg::WIDTH_W-1:0]  rc_x, rc2_x;
	bfg_pkg::pos_t                pos;

	always_comb begin
		if (width == '0)
			w_eff = bfg_pkg::WIDTH_W'(1);
		else if (width > bfg_pkg::WIDTH_W'(bfg_pkg::MAX_WIDTH))
			w_eff = bfg_pkg::WIDTH_W'(bfg_pkg::MAX_WIDTH);
		else
			w_eff = width;
		if (height == '0)
			h_eff = bfg_pkg::HEIGHT_W'(1);
		else if (height > bfg_pkg::HEIGHT_W'(bfg_pkg::MAX_HEIGHT))
			h_eff = bfg_pkg::HEIGHT_W'(bfg_pkg::MAX_HEIGHT);
		else
			h_eff = height;
	end

	always_comb begin
		row_x  = bfg_pkg::HEIGHT_W'(row_q);
		col_x  = bfg_pkg::WIDTH_W'(col_q);
		r_x    = bfg_pkg::HEIGHT_W'(radius);
		r2_x   = bfg_pkg::HEIGHT_W'({radius, 1'b0});
		rc_x   = bfg_pkg::WIDTH_W'(radius);
		rc2_x  = bfg_pkg::WIDTH_W'({radius, 1'b0});
		row_nx = row_x + bfg_pkg::HEIGHT_W'(1);
		col_nx = col_x + bfg_pkg::WIDTH_W'(1);
		pos.row  = row_q;
		pos.col  = col_q;
		pos.frow = row_q - bfg_pkg::ROW_W'(radius);
		pos.fcol = col_q - bfg_pkg::COL_W'(radius);
		// The pixel r rows and r columns back is interior exactly when this one
		// lies beyond 2r from the first edges and inside the image.
		pos.emit_f = (row_x > r2_x) && (row_x < h_eff) && (col_x > rc2_x) && (col_x < w_eff);
		pos.emit_g = !((row_x > r_x) && (row_x + r_x < h_eff)
			&& (col_x > rc_x) && (col_x + rc_x < w_eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			v_s1  <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			if (in_valid) begin
				if (col_nx >= w_eff) begin
					col_q <= '0;
					row_q <= (row_nx >= h_eff) ? '0 : row_nx[bfg_pkg::ROW_W-1:0];
				end else begin
					col_q <= col_nx[bfg_pkg::COL_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= pos;
			pix_s1 <= in_pix;
		end
	end
endmodule

// ----- rtl/bfg_lines.sv -----
`timescale 1ns / 1ps
module bfg_lines (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 v_s1,
	input  bfg_pkg::pos_t                        pos_s1,
	input  bfg_pkg::rgb_t                        pix_s1,
	output logic                                 v_s2,
	output bfg_pkg::pos_t                        pos_s2,
	output bfg_pkg::rgb_t [bfg_pkg::WIN_SIDE-1:0] vec_s2
);
	bfg_pkg::rgb_t                     pix_s2;
	bfg_pkg::rgb_t [bfg_pkg::LINES-1:0] rd_s2;
	bfg_pkg::rgb_t [bfg_pkg::LINES-1:0] wdata;
	logic [bfg_pkg::ADDR_W-1:0]        ra, wa;
	logic                              fwd;

	assign ra  = bfg_pkg::ADDR_W'(pos_s1.col);
	assign wa  = bfg_pkg::ADDR_W'(pos_s2.col);
	// With a one-pixel-wide image two successive pixels hit the same column.
	assign fwd = v_s2 && (wa == ra);

	always_comb begin
		vec_s2[0] = pix_s2;
		for (int k = 1; k < bfg_pkg::WIN_SIDE; k++)
			vec_s2[k] = rd_s2[k-1];
		wdata[0] = pix_s2;
		for (int k = 1; k < bfg_pkg::LINES; k++)
			wdata[k] = rd_s2[k-1];
	end

	for (genvar k = 0; k < bfg_pkg::LINES; k++) begin : g_line
		bfg_pkg::rgb_t mem [bfg_pkg::MAX_WIDTH];
		always_ff @(posedge clk) begin
			if (en && v_s2)
				mem[wa] <= wdata[k];
			if (en)
				rd_s2[k] <= fwd ? wdata[k] : mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s2 <= pos_s1;
			pix_s2 <= pix_s1;
		end
	end
endmodule

// ----- rtl/bfg_window.sv -----
`timescale 1ns / 1ps
module bfg_window (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  v_s2,
	input  bfg_pkg::pos_t                         pos_s2,
	input  bfg_pkg::rgb_t [bfg_pkg::WIN_SIDE-1:0] vec_s2,
	input  logic [bfg_pkg::FACTOR_W-1:0]          factor,
	input  logic [bfg_pkg::RAD_W-1:0]             radius,
	output logic                                  v_s4,
	output bfg_pkg::pos_t                         pos_s4,
	output bfg_pkg::byte_t                        grey_s4,
	output bfg_pkg::rgb_t                         fsum
);
	logic                                   v_s3;
	bfg_pkg::pos_t                          pos_s3;
	bfg_pkg::rgb_t [bfg_pkg::WIN_SIDE-1:0]  tap_s3;
	bfg_pkg::rgb_t                          ctr_s3;
	logic [2:0][23:0]                       gp_s3;
	bfg_pkg::rgb_t                          colsum;
	bfg_pkg::rgb_t [bfg_pkg::WIN_SIDE-1:0]  cs_q;
	bfg_pkg::rgb_t [bfg_pkg::WIN_SIDE-1:0]  ctr_q;
	logic [bfg_pkg::WIN_IDX_W-1:0]          ridx;
	logic [bfg_pkg::WIN_IDX_W:0]            span;
	logic [24:0]                            gsum;

	assign ridx = bfg_pkg::WIN_IDX_W'(radius);
	assign span = (bfg_pkg::WIN_IDX_W + 1)'({radius, 1'b0});

	// Each tap is scaled as it enters, so only column sums and the unscaled centre pixel need storing.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < bfg_pkg::WIN_SIDE; k++)
				for (int c = 0; c < 3; c++)
					tap_s3[k][c] <= 8'((24'(vec_s2[k][c]) * 24'(factor)) >> 16);
			ctr_s3   <= vec_s2[ridx];
			gp_s3[0] <= 24'(vec_s2[0][0]) * 24'(bfg_pkg::W_GREY_A);
			gp_s3[1] <= 24'(vec_s2[0][1]) * 24'(bfg_pkg::W_GREY_B);
			gp_s3[2] <= 24'(vec_s2[0][2]) * 24'(bfg_pkg::W_GREY_C);
			pos_s3   <= pos_s2;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			colsum[c] = '0;
			for (int k = 0; k < bfg_pkg::WIN_SIDE; k++)
				if ((bfg_pkg::WIN_IDX_W + 1)'(k) <= span)
					colsum[c] = colsum[c] + tap_s3[k][c];
		end
		gsum = 25'(gp_s3[0]) + 25'(gp_s3[1]) + 25'(gp_s3[2]);
	end

	always_ff @(posedge clk) begin
		if (en && v_s3) begin
			cs_q[0]  <= colsum;
			ctr_q[0] <= ctr_s3;
			for (int k = 1; k < bfg_pkg::WIN_SIDE; k++) begin
				cs_q[k]  <= cs_q[k-1];
				ctr_q[k] <= ctr_q[k-1];
			end
		end
		if (en) begin
			pos_s4  <= pos_s3;
			grey_s4 <= gsum[23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Sums wrap at 256, which is the required result.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			fsum[c] = ctr_q[ridx][c];
			for (int k = 0; k < bfg_pkg::WIN_SIDE; k++)
				if ((bfg_pkg::WIN_IDX_W + 1)'(k) <= span)
					fsum[c] = fsum[c] + cs_q[k][c];
		end
	end
endmodule

// ----- rtl/bfg_emit.sv -----
`timescale 1ns / 1ps
module bfg_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           v_s4,
	input  bfg_pkg::pos_t  pos_s4,
	input  bfg_pkg::byte_t grey_s4,
	input  bfg_pkg::rgb_t  fsum,
	output logic           en,
	res_if.source          res_out
);
	logic           v_s5;
	bfg_pkg::pos_t  pos_s5;
	bfg_pkg::rgb_t  fsum_s5;
	bfg_pkg::byte_t grey_s5;
	logic           sent_q;
	logic           have, first_f, last, done;

	assign have    = pos_s5.emit_f || pos_s5.emit_g;
	assign first_f = pos_s5.emit_f && !sent_q;
	assign last    = first_f ? !pos_s5.emit_g : 1'b1;
	assign done    = !have || (res_out.ready && last);
	assign en      = !v_s5 || done;

	assign res_out.valid       = v_s5 && have;
	assign res_out.out_row     = first_f ? pos_s5.frow : pos_s5.row;
	assign res_out.out_col     = first_f ? pos_s5.fcol : pos_s5.col;
	assign res_out.res_a       = first_f ? fsum_s5[0] : grey_s5;
	assign res_out.res_b       = first_f ? fsum_s5[1] : grey_s5;
	assign res_out.res_c       = first_f ? fsum_s5[2] : grey_s5;
	assign res_out.is_filtered = first_f;
	assign res_out.last_of_run = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5   <= 1'b0;
			sent_q <= 1'b0;
		end else if (en) begin
			v_s5   <= v_s4;
			sent_q <= 1'b0;
		end else if (res_out.valid && res_out.ready) begin
			sent_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s5  <= pos_s4;
			fsum_s5 <= fsum;
			grey_s5 <= grey_s4;
		end
	end

	a_sent_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sent_q |-> (v_s5 && pos_s5.emit_f && pos_s5.emit_g))
		else $error("second result pending without a pair");
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && res_out.ready && res_out.is_filtered && !res_out.last_of_run)
		|=> (res_out.valid && !res_out.is_filtered && res_out.last_of_run))
		else $error("grey result did not follow window result");
	a_empty_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !have) |-> en)
		else $error("item without results stalled the pipeline");
endmodule

// ----- rtl/box_filter_with_gray_border.sv -----
`timescale 1ns / 1ps
// Box filter with gray border for a raster stream of three-channel 8-bit pixels.
// One pixel is accepted per clock unless the output stalls; the pipeline is five
// register stages deep (position, line memory read, tap scaling, window column
// sums, output). An input that causes two results (a delayed window result, then
// its own gray border result) holds the output stage until both are taken. Six
// line memories of 1024 x 24 bits hold the previous rows; they need no clearing
// after reset. Configuration must be written only while the stream is idle, which
// the block does not enforce; the write channel is always ready.
module box_filter_with_gray_border (
	input  logic  clk,
	input  logic  arst_n,
	pix_if.sink   pix_in,
	res_if.source res_out,
	cfg_if.sink   cfg
);
	logic [bfg_pkg::WIDTH_W-1:0]  width_q;
	logic [bfg_pkg::HEIGHT_W-1:0] height_q;
	logic [bfg_pkg::RAD_W-1:0]    radius_q;
	logic [bfg_pkg::FACTOR_W-1:0] factor_q;
	logic [bfg_pkg::RAD_W-1:0]    r_eff;

	logic                                  en;
	logic                                  v_s1, v_s2, v_s4;
	bfg_pkg::pos_t                         pos_s1, pos_s2, pos_s4;
	bfg_pkg::rgb_t                         pix_s1, fsum, in_pix;
	bfg_pkg::rgb_t [bfg_pkg::WIN_SIDE-1:0] vec_s2;
	bfg_pkg::byte_t                        grey_s4;

	assign cfg.ready    = 1'b1;
	assign pix_in.ready = en;
	assign in_pix       = {pix_in.chan_c, pix_in.chan_b, pix_in.chan_a};
	assign r_eff = (32'(radius_q) > bfg_pkg::MAX_RADIUS)
		? bfg_pkg::RAD_W'(bfg_pkg::MAX_RADIUS) : radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bfg_pkg::WIDTH_W'(1024);
			height_q <= bfg_pkg::HEIGHT_W'(1024);
			radius_q <= bfg_pkg::RAD_W'(1);
			factor_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				bfg_pkg::REG_WIDTH:  width_q  <= cfg.data[bfg_pkg::WIDTH_W-1:0];
				bfg_pkg::REG_HEIGHT: height_q <= cfg.data[bfg_pkg::HEIGHT_W-1:0];
				bfg_pkg::REG_RADIUS: radius_q <= cfg.data[bfg_pkg::RAD_W-1:0];
				bfg_pkg::REG_FACTOR: factor_q <= cfg.data[bfg_pkg::FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	bfg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(pix_in.valid), .in_pix(in_pix),
		.width(width_q), .height(height_q), .radius(r_eff),
		.v_s1(v_s1), .pos_s1(pos_s1), .pix_s1(pix_s1)
	);

	bfg_lines u_lines (
		.clk(clk), .arst_n(arst_n), .en(en), .v_s1(v_s1), .pos_s1(pos_s1),
		.pix_s1(pix_s1), .v_s2(v_s2), .pos_s2(pos_s2), .vec_s2(vec_s2)
	);

	bfg_window u_window (
		.clk(clk), .arst_n(arst_n), .en(en), .v_s2(v_s2), .pos_s2(pos_s2),
		.vec_s2(vec_s2), .factor(factor_q), .radius(r_eff), .v_s4(v_s4),
		.pos_s4(pos_s4), .grey_s4(grey_s4), .fsum(fsum)
	);

	bfg_emit u_emit (
		.clk(clk), .arst_n(arst_n), .v_s4(v_s4), .pos_s4(pos_s4), .grey_s4(grey_s4),
		.fsum(fsum), .en(en), .res_out(res_out)
	);
endmodule
